FILE: src/gsac_pkg.sv
// Shared constants, types and tables for the green spill alpha compositor.
package gsac_pkg;

  localparam int PIX_W  = 8;
  localparam int STR_W  = 7;
  localparam int Q16_W  = 17;   // Q16 value 0..65536 plus headroom for spill gain
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Pixel pipeline depth: 3 in the scaler, 3 for spill, 3 in the blender.
  localparam int PIPE_DEPTH = 9;

  // Word index of the spill strength register (paddr[2]).
  localparam logic [ADDR_W-3:0] REG_SPILL_STRENGTH = '0;

  localparam int STR_MAX = 100;
  localparam int STR_DEN = 100;

  // Alpha scaling: X = floor((v*a*65536 + 32512) / 65025)
  //              = v*a + floor((511*v*a + 32512) / 65025)
  localparam int M_W = 25;      // 511*p + 32512 < 2^25
  localparam int R_W = 17;
  localparam int E_W = 10;
  localparam logic [R_W-1:0] SCALE_RECIP = 17'd66051;   // floor(2^32 / 65025)
  localparam logic [R_W-1:0] SCALE_DEN   = 17'd65025;
  localparam logic [M_W-1:0] SCALE_BIAS  = 25'd32512;

  // floor(t / 255) = (t * 32897) >> 23, exact for t below 66052
  localparam logic [15:0] DIV255_MAGIC = 16'd32897;

  typedef logic [Q16_W-1:0] q16_t;
  typedef logic [2**STR_W-1:0][Q16_W-1:0] k_table_t;

  // Strength in percent to Q16, saturated at 100 percent.
  function automatic k_table_t build_k_table();
    k_table_t    tab;
    int unsigned s;
    for (int i = 0; i < 2**STR_W; i++) begin
      s = (i > STR_MAX) ? STR_MAX : i;
      tab[i] = Q16_W'((s * 65536 + 50) / STR_DEN);
    end
    return tab;
  endfunction

  localparam k_table_t K_TABLE = build_k_table();

endpackage

FILE: src/gsac_scale.sv
// Three-stage alpha scaler: one 8-bit channel times alpha/255 into Q16.
module gsac_scale import gsac_pkg::*; (
  input  logic             clk,
  input  logic [PIX_W-1:0] chan,
  input  logic [PIX_W-1:0] alpha,
  output q16_t             scaled
);

  logic [2*PIX_W-1:0] prod1;
  logic [2*PIX_W-1:0] prod2;
  logic [M_W-1:0]     m_c;
  logic [M_W-1:0]     m2;
  logic [M_W+R_W-1:0] est_prod;
  logic [E_W-1:0]     e2;
  logic [M_W+1:0]     ep;
  logic [M_W+1:0]     rem;
  logic               corr;

  // stage 2: remainder numerator and reciprocal estimate (low by at most one)
  always_comb begin
    m_c      = {prod1, 9'b0} - M_W'(prod1) + SCALE_BIAS;
    est_prod = {{R_W{1'b0}}, m_c} * {{M_W{1'b0}}, SCALE_RECIP};
  end

  // stage 3: one correction step
  always_comb begin
    ep   = (M_W+2)'(e2) * (M_W+2)'(SCALE_DEN);
    rem  = (M_W+2)'(m2) - ep;
    corr = rem >= (M_W+2)'(SCALE_DEN);
  end

  always_ff @(posedge clk) begin
    prod1  <= (2*PIX_W)'(chan) * (2*PIX_W)'(alpha);
    prod2  <= prod1;
    m2     <= m_c;
    e2     <= est_prod[M_W+R_W-1 -: E_W];
    scaled <= Q16_W'(prod2) + Q16_W'(e2) + Q16_W'(corr);
  end

endmodule

FILE: src/gsac_blend.sv
// Three-stage blender: Q16 foreground to 8 bits, then mix over background.
module gsac_blend import gsac_pkg::*; (
  input  logic             clk,
  input  q16_t             fg_q16,
  input  logic [PIX_W-1:0] bg,
  input  logic [PIX_W-1:0] alpha,
  output logic [PIX_W-1:0] result
);

  logic [Q16_W+8:0]   xs;
  logic [Q16_W-8:0]   f_c;
  logic [PIX_W-1:0]   f7;
  logic [PIX_W-1:0]   bg7;
  logic [PIX_W-1:0]   a7;
  logic [15:0]        t_c;
  logic [15:0]        t8;
  logic [31:0]        q_prod;
  logic [8:0]         quot;

  always_comb begin
    xs  = {1'b0, fg_q16, 8'b0} - (Q16_W+9)'(fg_q16) + (Q16_W+9)'(32768);
    f_c = xs[Q16_W+8:16];
  end

  always_comb begin
    t_c = 16'(bg7) * 16'(8'd255 - a7) + 16'(f7) * 16'(a7) + 16'd127;
  end

  always_comb begin
    q_prod = {16'b0, t8} * {16'b0, DIV255_MAGIC};
    quot   = q_prod[31:23];
  end

  always_ff @(posedge clk) begin
    f7     <= (f_c > (Q16_W-7)'(255)) ? 8'd255 : f_c[7:0];
    bg7    <= bg;
    a7     <= alpha;
    t8     <= t_c;
    result <= (quot > 9'd255) ? 8'd255 : quot[7:0];
  end

endmodule

FILE: src/green_spill_alpha_composite.sv
// Top level of the green spill suppressing alpha compositor.
// Takes one pixel per clock: busy is never raised, so a request may be issued
// with start in every cycle. Each request gives exactly one result, marked by
// done, after 3 stages of alpha scaling, 3 of spill correction and 3 of
// blending; results come out in request order and must be taken when shown.
// spill_strength sits at byte address 0 and is meant to be written only
// while no pixel is in flight; values above 100 act as 100.
module green_spill_alpha_composite import gsac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  fg_blue,
  input  logic [PIX_W-1:0]  fg_green,
  input  logic [PIX_W-1:0]  fg_red,
  input  logic [PIX_W-1:0]  bg_blue,
  input  logic [PIX_W-1:0]  bg_green,
  input  logic [PIX_W-1:0]  bg_red,
  input  logic [PIX_W-1:0]  alpha,
  output logic              done,
  output logic [PIX_W-1:0]  out_blue,
  output logic [PIX_W-1:0]  out_green,
  output logic [PIX_W-1:0]  out_red,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic [PIX_W-1:0] bg_b;
    logic [PIX_W-1:0] bg_g;
    logic [PIX_W-1:0] bg_r;
    logic [PIX_W-1:0] a;
  } side_t;

  localparam int SIDE_DEPTH = 6;

  logic [STR_W-1:0]      spill_strength;
  q16_t                  k_reg;
  logic                  cfg_wr;
  logic [PIPE_DEPTH-1:0] vld;
  side_t                 side [SIDE_DEPTH];

  q16_t                  xb3, xg3, xr3;
  q16_t                  xb4, xg4, xr4, sp4;
  q16_t                  mbr;
  q16_t                  xb5, xg5, xr5;
  logic [2*Q16_W-1:0]    prod5;
  logic [2*Q16_W:0]      ks_sum;
  logic [2*Q16_W:0]      h_sum;
  logic [Q16_W+1:0]      ks;
  logic [Q16_W:0]        h;
  q16_t                  xb6, xg6, xr6;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign done   = vld[PIPE_DEPTH-1];
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_SPILL_STRENGTH);

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_SPILL_STRENGTH) begin
      prdata = {{(DATA_W-STR_W){1'b0}}, spill_strength};
    end
  end

  // Config and valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_strength <= '0;
      k_reg          <= '0;
      vld            <= '0;
    end else begin
      if (cfg_wr) begin
        spill_strength <= pwdata[STR_W-1:0];
        k_reg          <= K_TABLE[pwdata[STR_W-1:0]];
      end
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  // background and alpha ride alongside the scaler and spill stages
  always_ff @(posedge clk) begin
    side[0] <= '{bg_b: bg_blue, bg_g: bg_green, bg_r: bg_red, a: alpha};
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side[i] <= side[i-1];
    end
  end

  gsac_scale u_scale_b (.clk(clk), .chan(fg_blue),  .alpha(alpha), .scaled(xb3));
  gsac_scale u_scale_g (.clk(clk), .chan(fg_green), .alpha(alpha), .scaled(xg3));
  gsac_scale u_scale_r (.clk(clk), .chan(fg_red),   .alpha(alpha), .scaled(xr3));

  always_comb begin
    mbr    = (xb3 > xr3) ? xb3 : xr3;
    ks_sum = (2*Q16_W+1)'(prod5) + (2*Q16_W+1)'(32768);
    h_sum  = (2*Q16_W+1)'(prod5) + (2*Q16_W+1)'(65536);
    ks     = ks_sum[2*Q16_W:16];
    h      = h_sum[2*Q16_W:17];
  end

  // spill measure, strength-scaled correction amount, correction
  always_ff @(posedge clk) begin
    xb4   <= xb3;
    xg4   <= xg3;
    xr4   <= xr3;
    sp4   <= (xg3 > mbr) ? xg3 - mbr : '0;
    xb5   <= xb4;
    xg5   <= xg4;
    xr5   <= xr4;
    prod5 <= (2*Q16_W)'(k_reg) * (2*Q16_W)'(sp4);
    xg6   <= ((Q16_W+2)'(xg5) > ks) ? xg5 - ks[Q16_W-1:0] : '0;
    // h stays at or below one half, so blue and red fit in Q16_W bits
    xb6   <= Q16_W'((Q16_W+1)'(xb5) + h);
    xr6   <= Q16_W'((Q16_W+1)'(xr5) + h);
  end

  gsac_blend u_blend_b (.clk(clk), .fg_q16(xb6), .bg(side[SIDE_DEPTH-1].bg_b),
                        .alpha(side[SIDE_DEPTH-1].a), .result(out_blue));
  gsac_blend u_blend_g (.clk(clk), .fg_q16(xg6), .bg(side[SIDE_DEPTH-1].bg_g),
                        .alpha(side[SIDE_DEPTH-1].a), .result(out_green));
  gsac_blend u_blend_r (.clk(clk), .fg_q16(xr6), .bg(side[SIDE_DEPTH-1].bg_r),
                        .alpha(side[SIDE_DEPTH-1].a), .result(out_red));

`ifndef ASSERT_OFF
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result without a request");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k_reg <= Q16_W'(65536))
    else $error("strength factor above one");

  a_spill_le_green: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> sp4 <= xg4)
    else $error("spill exceeds green");

  a_k_only_on_write: assert property (@(posedge clk) disable iff (rst)
    !cfg_wr |=> $stable(k_reg))
    else $error("strength factor changed without a write");
`endif

endmodule
